>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers sampled on clk_i; FBW_ASSERT is gated by rst_ni
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked only out of reset
`define FBW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fbw assertion failed");
// property checked during reset too
`define FBW_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("fbw assertion failed");
`else
`define FBW_ASSERT(lbl, prop)
`define FBW_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> hdl/fbw_pkg.sv
// ----------------------------------------------------------------------------
// fbw_pkg
// Shared widths, command codes and microcode word format of the
// write-buffer sequencer
// ----------------------------------------------------------------------------
package fbw_pkg;

  // geometry
  localparam int unsigned SLOTS_PER_BLOCK = 8;
  localparam int unsigned SLOT_W          = $clog2(SLOTS_PER_BLOCK);
  localparam int unsigned BLOCK_W         = 8;
  localparam int unsigned ADDR_W          = 20;
  localparam int unsigned SECTOR_SHIFT    = 9;
  localparam int unsigned CMD_W           = 3;
  localparam int unsigned STEP_W          = 3;

  // flash command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_COPY_TO_BUF  = 3'd0,
    CMD_ERASE_MAIN   = 3'd1,
    CMD_COPY_TO_MAIN = 3'd2,
    CMD_ERASE_BUF    = 3'd3,
    CMD_STORE        = 3'd4
  } cmd_e;

  // microcode addresses
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t S_FETCH      = 3'd0;
  localparam step_t S_DISPATCH   = 3'd1;
  localparam step_t S_COPY_BUF   = 3'd2;
  localparam step_t S_ERASE_MAIN = 3'd3;
  localparam step_t S_COPY_MAIN  = 3'd4;
  localparam step_t S_ERASE_BUF  = 3'd5;
  localparam step_t S_STORE      = 3'd6;

  // block index source of an emitted command
  typedef enum logic [1:0] {
    BLK_OPEN  = 2'd0,
    BLK_BUF   = 2'd1,
    BLK_WRITE = 2'd2
  } blk_sel_e;

  // slot source of an emitted command
  typedef enum logic [1:0] {
    SLOT_ZERO  = 2'd0,
    SLOT_CNT   = 2'd1,
    SLOT_WRITE = 2'd2
  } slot_sel_e;

  // sequencing of a step once it is done
  typedef enum logic [2:0] {
    BR_NEXT     = 3'd0,
    BR_WAIT     = 3'd1,
    BR_DISPATCH = 3'd2,
    BR_FULL     = 3'd3,
    BR_RETURN   = 3'd4
  } branch_e;

  // one control word
  typedef struct packed {
    cmd_e      cmd;
    logic      emit;
    logic      slot_loop;
    logic      skip_dirty;
    blk_sel_e  blk_sel;
    slot_sel_e slot_sel;
    logic      do_open;
    logic      do_close;
    branch_e   br;
    step_t     next;
  } uword_t;

endpackage

>>> hdl/fbw_in_if.sv
// ----------------------------------------------------------------------------
// fbw_in_if
// Request channel: sector write or flush request
// ----------------------------------------------------------------------------
interface fbw_in_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic [fbw_pkg::ADDR_W-1:0]        write_address;

  modport source (output valid, output kind, output write_address, input ready);
  modport sink   (input valid, input kind, input write_address, output ready);
endinterface

>>> hdl/fbw_out_if.sv
// ----------------------------------------------------------------------------
// fbw_out_if
// Command channel: one flash command per transaction
// ----------------------------------------------------------------------------
interface fbw_out_if;
  logic                              valid;
  logic                              ready;
  logic [fbw_pkg::CMD_W-1:0]         command;
  logic [fbw_pkg::BLOCK_W-1:0]       block_index;
  logic [fbw_pkg::SLOT_W-1:0]        slot;
  logic                              last;

  modport source (output valid, output command, output block_index, output slot,
                  output last, input ready);
  modport sink   (input valid, input command, input block_index, input slot,
                  input last, output ready);
endinterface

>>> hdl/fbw_ucode_rom.sv
// ----------------------------------------------------------------------------
// fbw_ucode_rom
// Control store of the sequencer: one control word per step
// ----------------------------------------------------------------------------
module fbw_ucode_rom (
  input  fbw_pkg::step_t  step_i,
  output fbw_pkg::uword_t uword_o
);

  fbw_pkg::uword_t uw;

  // program
  always_comb begin
    uw            = '0;
    uw.cmd        = fbw_pkg::CMD_STORE;
    uw.blk_sel    = fbw_pkg::BLK_OPEN;
    uw.slot_sel   = fbw_pkg::SLOT_ZERO;
    uw.br         = fbw_pkg::BR_NEXT;
    uw.next       = fbw_pkg::S_FETCH;
    case (step_i)
      fbw_pkg::S_FETCH: begin
        uw.br   = fbw_pkg::BR_WAIT;
        uw.next = fbw_pkg::S_DISPATCH;
      end
      fbw_pkg::S_DISPATCH: begin
        uw.br = fbw_pkg::BR_DISPATCH;
      end
      // clean sectors of the open block into the buffer
      fbw_pkg::S_COPY_BUF: begin
        uw.cmd        = fbw_pkg::CMD_COPY_TO_BUF;
        uw.emit       = 1'b1;
        uw.slot_loop  = 1'b1;
        uw.skip_dirty = 1'b1;
        uw.slot_sel   = fbw_pkg::SLOT_CNT;
        uw.next       = fbw_pkg::S_ERASE_MAIN;
      end
      fbw_pkg::S_ERASE_MAIN: begin
        uw.cmd  = fbw_pkg::CMD_ERASE_MAIN;
        uw.emit = 1'b1;
        uw.next = fbw_pkg::S_COPY_MAIN;
      end
      // every slot back to main
      fbw_pkg::S_COPY_MAIN: begin
        uw.cmd       = fbw_pkg::CMD_COPY_TO_MAIN;
        uw.emit      = 1'b1;
        uw.slot_loop = 1'b1;
        uw.slot_sel  = fbw_pkg::SLOT_CNT;
        uw.next      = fbw_pkg::S_ERASE_BUF;
      end
      fbw_pkg::S_ERASE_BUF: begin
        uw.cmd      = fbw_pkg::CMD_ERASE_BUF;
        uw.emit     = 1'b1;
        uw.blk_sel  = fbw_pkg::BLK_BUF;
        uw.do_close = 1'b1;
        uw.br       = fbw_pkg::BR_RETURN;
      end
      fbw_pkg::S_STORE: begin
        uw.cmd      = fbw_pkg::CMD_STORE;
        uw.emit     = 1'b1;
        uw.blk_sel  = fbw_pkg::BLK_WRITE;
        uw.slot_sel = fbw_pkg::SLOT_WRITE;
        uw.do_open  = 1'b1;
        uw.br       = fbw_pkg::BR_FULL;
      end
      default: begin
        uw.next = fbw_pkg::S_FETCH;
      end
    endcase
  end

  assign uword_o = uw;

endmodule

>>> hdl/flash_block_write_buffer_sequencer.sv
// Command path: an accepted request passes the dispatch step, then the first emitting
// step loads the output register; a flush may first walk past dirty slots.
// Throughput: one request at a time; a request runs the fetch and dispatch steps and,
// per flush, microcode that walks all slots twice (one step per cycle, one command
// per cycle, while the output register is not stalled).
// Reset: no block open, dirty mask clear, buffer_block 255, output empty.
// ----------------------------------------------------------------------------
// flash_block_write_buffer_sequencer
// Microcoded sequencer that gathers sector writes in a spare erase block and
// issues the flash commands of store and flush
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flash_block_write_buffer_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fbw_pkg::BLOCK_W-1:0]   cfg_wdata_i,
  fbw_in_if.sink                        req_i,
  fbw_out_if.source                     rsp_o
);

  localparam int unsigned SLOTS  = fbw_pkg::SLOTS_PER_BLOCK;
  localparam int unsigned SLOT_W = fbw_pkg::SLOT_W;
  localparam int unsigned BLK_W  = fbw_pkg::BLOCK_W;

  fbw_pkg::uword_t       uw;
  fbw_pkg::step_t        step_q, step_d, ret_q, ret_d;
  logic [SLOT_W-1:0]     cnt_q, cnt_d;
  logic                  open_valid_q, open_valid_d;
  logic [BLK_W-1:0]      open_block_q, open_block_d;
  logic [SLOTS-1:0]      dirty_q, dirty_d;
  logic [BLK_W-1:0]      buffer_block_q;
  logic                  kind_q;
  logic [BLK_W-1:0]      wblk_q;
  logic [SLOT_W-1:0]     wslot_q;
  logic                  req_fire;
  logic [SLOTS-1:0]      mask_or;
  logic                  full_after;
  logic                  emit_now, out_free, step_done, loop_end, emit_fire;
  logic                  last_cmd;
  logic [BLK_W-1:0]      emit_blk;
  logic [SLOT_W-1:0]     emit_slot;
  logic                  rsp_valid_q;
  fbw_pkg::cmd_e         rsp_cmd_q;
  logic [BLK_W-1:0]      rsp_blk_q;
  logic [SLOT_W-1:0]     rsp_slot_q;
  logic                  rsp_last_q;

  // control store
  fbw_ucode_rom u_rom (
    .step_i  (step_q),
    .uword_o (uw)
  );

  // request handshake
  assign req_i.ready = (uw.br == fbw_pkg::BR_WAIT);
  assign req_fire    = req_i.valid && req_i.ready;

  // step condition terms
  assign mask_or    = dirty_q | (SLOTS'(1) << wslot_q);
  assign full_after = &mask_or;
  assign emit_now   = uw.emit && !(uw.skip_dirty && dirty_q[cnt_q]);
  assign out_free   = !rsp_valid_q || rsp_o.ready;
  assign step_done  = (uw.br != fbw_pkg::BR_WAIT) && (!emit_now || out_free);
  assign loop_end   = !uw.slot_loop || (cnt_q == SLOT_W'(SLOTS - 1));
  assign emit_fire  = step_done && emit_now;
  assign last_cmd   = ((uw.br == fbw_pkg::BR_RETURN) && (ret_q == fbw_pkg::S_FETCH)) ||
                      ((uw.br == fbw_pkg::BR_FULL) && !full_after);

  // command field selection
  always_comb begin
    case (uw.blk_sel)
      fbw_pkg::BLK_BUF:   emit_blk = buffer_block_q;
      fbw_pkg::BLK_WRITE: emit_blk = wblk_q;
      default:            emit_blk = open_block_q;
    endcase
    case (uw.slot_sel)
      fbw_pkg::SLOT_CNT:   emit_slot = cnt_q;
      fbw_pkg::SLOT_WRITE: emit_slot = wslot_q;
      default:             emit_slot = '0;
    endcase
  end

  // sequencer next state
  always_comb begin
    step_d       = step_q;
    ret_d        = ret_q;
    cnt_d        = cnt_q;
    open_valid_d = open_valid_q;
    open_block_d = open_block_q;
    dirty_d      = dirty_q;
    if (req_fire) begin
      step_d = uw.next;
    end else if (step_done) begin
      if (!loop_end) begin
        cnt_d = cnt_q + SLOT_W'(1);
      end else begin
        cnt_d = '0;
        if (uw.do_close) begin
          open_valid_d = 1'b0;
          dirty_d      = '0;
        end
        if (uw.do_open) begin
          open_valid_d = 1'b1;
          open_block_d = wblk_q;
          dirty_d      = mask_or;
        end
        case (uw.br)
          fbw_pkg::BR_DISPATCH: begin
            if (kind_q) begin
              step_d = open_valid_q ? fbw_pkg::S_COPY_BUF : fbw_pkg::S_FETCH;
              ret_d  = fbw_pkg::S_FETCH;
            end else if (open_valid_q &&
                         ((wblk_q != open_block_q) || dirty_q[wslot_q])) begin
              step_d = fbw_pkg::S_COPY_BUF;
              ret_d  = fbw_pkg::S_STORE;
            end else begin
              step_d = fbw_pkg::S_STORE;
            end
          end
          fbw_pkg::BR_FULL: begin
            step_d = full_after ? fbw_pkg::S_COPY_BUF : fbw_pkg::S_FETCH;
            ret_d  = fbw_pkg::S_FETCH;
          end
          fbw_pkg::BR_RETURN: step_d = ret_q;
          default:            step_d = uw.next;
        endcase
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q         <= fbw_pkg::S_FETCH;
      ret_q          <= fbw_pkg::S_FETCH;
      cnt_q          <= '0;
      open_valid_q   <= 1'b0;
      open_block_q   <= '0;
      dirty_q        <= '0;
      buffer_block_q <= '1;
      rsp_valid_q    <= 1'b0;
    end else begin
      step_q       <= step_d;
      ret_q        <= ret_d;
      cnt_q        <= cnt_d;
      open_valid_q <= open_valid_d;
      open_block_q <= open_block_d;
      dirty_q      <= dirty_d;
      if (cfg_we_i) begin
        buffer_block_q <= cfg_wdata_i;
      end
      if (emit_fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      kind_q  <= req_i.kind;
      wslot_q <= req_i.write_address[fbw_pkg::SECTOR_SHIFT +: SLOT_W];
      wblk_q  <= req_i.write_address[fbw_pkg::SECTOR_SHIFT + SLOT_W +: BLK_W];
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      rsp_cmd_q  <= uw.cmd;
      rsp_blk_q  <= emit_blk;
      rsp_slot_q <= emit_slot;
      rsp_last_q <= last_cmd;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.command     = rsp_cmd_q;
  assign rsp_o.block_index = rsp_blk_q;
  assign rsp_o.slot        = rsp_slot_q;
  assign rsp_o.last        = rsp_last_q;

  // checks
  `FBW_ASSERT(a_dirty_needs_open, (dirty_q != '0) |-> open_valid_q)
  `FBW_ASSERT(a_idle_not_full, (step_q == fbw_pkg::S_FETCH) |-> !(&dirty_q))
  `FBW_ASSERT(a_cnt_only_in_loop, (cnt_q != '0) |->
    ((step_q == fbw_pkg::S_COPY_BUF) || (step_q == fbw_pkg::S_COPY_MAIN)))
  `FBW_ASSERT(a_accept_dispatch, req_fire |=> (step_q == fbw_pkg::S_DISPATCH))

endmodule

>>> dv/fbw_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fbw_tb_pkg
// Request kind codes shared by the stimulus and the command checker
// ----------------------------------------------------------------------------
package fbw_tb_pkg;

  // request kinds on the request channel
  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_FLUSH = 1'b1
  } req_kind_e;

endpackage

>>> dv/fbw_command_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fbw_command_checker
// Watches the request, config and command channels of the write-buffer
// sequencer, predicts the flash commands of each accepted request and
// compares every command transaction field by field, in order
// ----------------------------------------------------------------------------
module fbw_command_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fbw_pkg::BLOCK_W-1:0] cfg_wdata_i,
  fbw_in_if                           req,
  fbw_out_if                          rsp,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          checked_o
);

  localparam int PRINT_LIMIT = 30;

  typedef struct {
    fbw_pkg::cmd_e               command;
    logic [fbw_pkg::BLOCK_W-1:0] block_index;
    logic [fbw_pkg::SLOT_W-1:0]  slot;
    logic                        last;
  } flash_cmd_t;

  // predicted buffer state
  logic                                open_valid;
  logic [fbw_pkg::BLOCK_W-1:0]         open_block;
  logic [fbw_pkg::SLOTS_PER_BLOCK-1:0] dirty_mask;
  logic [fbw_pkg::BLOCK_W-1:0]         buf_block;

  flash_cmd_t cmd_q[$];
  flash_cmd_t head;
  int         n_fail;
  int         n_checked;

  assign fail_count_o = n_fail;
  assign checked_o    = n_checked;
  assign pending_o    = cmd_q.size();

  // one line per mismatch, counted even when printing is capped
  task automatic report_mismatch(input string msg);
    if (n_fail < PRINT_LIMIT) begin
      $display("%0t mismatch: %s", $time, msg);
    end
    n_fail++;
  endtask

  task automatic queue_cmd(input fbw_pkg::cmd_e c, input logic [fbw_pkg::BLOCK_W-1:0] b,
                           input logic [fbw_pkg::SLOT_W-1:0] s);
    flash_cmd_t r;
    r.command     = c;
    r.block_index = b;
    r.slot        = s;
    r.last        = 1'b0;
    cmd_q.push_back(r);
  endtask

  // merge buffer and main block, then close it
  task automatic flush_open_block();
    for (int i = 0; i < fbw_pkg::SLOTS_PER_BLOCK; i++) begin
      if (!dirty_mask[i]) begin
        queue_cmd(fbw_pkg::CMD_COPY_TO_BUF, open_block, fbw_pkg::SLOT_W'(i));
      end
    end
    queue_cmd(fbw_pkg::CMD_ERASE_MAIN, open_block, '0);
    for (int i = 0; i < fbw_pkg::SLOTS_PER_BLOCK; i++) begin
      queue_cmd(fbw_pkg::CMD_COPY_TO_MAIN, open_block, fbw_pkg::SLOT_W'(i));
    end
    queue_cmd(fbw_pkg::CMD_ERASE_BUF, buf_block, '0);
    open_valid = 1'b0;
    dirty_mask = '0;
  endtask

  // expected commands of one accepted request
  task automatic predict_commands(input logic k, input logic [fbw_pkg::ADDR_W-1:0] a);
    int                          q_len0;
    logic [fbw_pkg::SLOT_W-1:0]  s;
    logic [fbw_pkg::BLOCK_W-1:0] b;
    q_len0 = cmd_q.size();
    s = a[fbw_pkg::SECTOR_SHIFT +: fbw_pkg::SLOT_W];
    b = a[fbw_pkg::SECTOR_SHIFT + fbw_pkg::SLOT_W +: fbw_pkg::BLOCK_W];
    if (k == fbw_tb_pkg::KIND_FLUSH) begin
      if (open_valid) flush_open_block();
    end else begin
      if (open_valid && b != open_block) flush_open_block();
      open_valid = 1'b1;
      open_block = b;
      // rewrite of a dirty slot flushes and reopens the same block
      if (dirty_mask[s]) begin
        flush_open_block();
        open_valid = 1'b1;
        open_block = b;
      end
      dirty_mask[s] = 1'b1;
      queue_cmd(fbw_pkg::CMD_STORE, b, s);
      if (&dirty_mask) flush_open_block();
    end
    if (cmd_q.size() > q_len0) cmd_q[cmd_q.size() - 1].last = 1'b1;
  endtask

  // predict on request transactions, compare on command transactions
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_valid = 1'b0;
      open_block = '0;
      dirty_mask = '0;
      buf_block  = 8'hff;
      cmd_q.delete();
      n_fail     = 0;
      n_checked  = 0;
    end else begin
      if (req.valid && req.ready) predict_commands(req.kind, req.write_address);
      if (cfg_we_i) buf_block = cfg_wdata_i;
      if (rsp.valid && rsp.ready) begin
        if (cmd_q.size() == 0) begin
          report_mismatch($sformatf("unexpected command %0d block %0d slot %0d",
                                    rsp.command, rsp.block_index, rsp.slot));
        end else begin
          head = cmd_q.pop_front();
          if (rsp.command !== head.command)
            report_mismatch($sformatf("command %0d: got %0d, expected %0d",
                                      n_checked, rsp.command, head.command));
          if (rsp.block_index !== head.block_index)
            report_mismatch($sformatf("block_index of command %0d: got %0d, expected %0d",
                                      n_checked, rsp.block_index, head.block_index));
          if (rsp.slot !== head.slot)
            report_mismatch($sformatf("slot of command %0d: got %0d, expected %0d",
                                      n_checked, rsp.slot, head.slot));
          if (rsp.last !== head.last)
            report_mismatch($sformatf("last of command %0d: got %0d, expected %0d",
                                      n_checked, rsp.last, head.last));
        end
        n_checked++;
      end
    end
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives sector writes and flush requests into the write-buffer sequencer
// through directed and random phases with varying idle and stall rates,
// buffer block settings and a long command stall; the checker beside the
// block predicts and compares every flash command
// ----------------------------------------------------------------------------
module tb_top;

  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 30;
  localparam int PHASE_ITEMS  = 62;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we;
  logic [fbw_pkg::BLOCK_W-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int checked;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_ask;
  int hold_served;
  int n_sent;

  logic [fbw_pkg::BLOCK_W-1:0] buf_cur;
  logic [fbw_pkg::BLOCK_W-1:0] hot_blk[3];

  fbw_in_if  req_if ();
  fbw_out_if rsp_if ();

  flash_block_write_buffer_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  fbw_command_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .req          (req_if),
    .rsp          (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("timeout with %0d commands outstanding", pending);
    $display("FAILED: results differ");
    $finish;
  end

  // command receiver: random stalls, or a long hold-off when asked
  initial begin
    rsp_if.ready = 1'b0;
    hold_served  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_ask != hold_served) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_served++;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // offer one request, called at a falling edge, returns at a falling edge
  task automatic send_req(input fbw_tb_pkg::req_kind_e k,
                          input logic [fbw_pkg::ADDR_W-1:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.kind          <= k;
    req_if.write_address <= a;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    n_sent++;
  endtask

  function automatic logic [fbw_pkg::ADDR_W-1:0] sector_addr(
    input logic [fbw_pkg::BLOCK_W-1:0] b,
    input logic [fbw_pkg::SLOT_W-1:0]  s);
    return {b, s, 9'($urandom)};
  endfunction

  // stop offering until every command is out and the block has settled
  task automatic drain_idle();
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_buffer_block(input logic [fbw_pkg::BLOCK_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    buf_cur    = v;
  endtask

  // mostly writes to a few hot blocks so masks fill up, plus flushes and noise
  task automatic run_random(input int n, input int hold_at, input int pause_at);
    int                          r;
    logic [fbw_pkg::BLOCK_W-1:0] b;
    for (int h = 0; h < 3; h++) hot_blk[h] = fbw_pkg::BLOCK_W'($urandom);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_ask++;
      if (i == pause_at) drain_idle();
      r = $urandom_range(99);
      if (r < 10) begin
        send_req(fbw_tb_pkg::KIND_FLUSH, fbw_pkg::ADDR_W'($urandom));
      end else begin
        if (r < 18) b = fbw_pkg::BLOCK_W'($urandom);
        else if (r < 24) b = buf_cur;
        else b = hot_blk[$urandom_range(2)];
        send_req(fbw_tb_pkg::KIND_WRITE, sector_addr(b, fbw_pkg::SLOT_W'($urandom)));
      end
    end
  endtask

  // stimulus
  initial begin
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    req_if.valid         = 1'b0;
    req_if.kind          = fbw_tb_pkg::KIND_WRITE;
    req_if.write_address = '0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    hold_ask             = 0;
    n_sent               = 0;
    buf_cur              = 8'hff;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: flush with nothing open, dirty rewrite, block switch,
    // write to the buffer block, full mask, address extremes
    send_req(fbw_tb_pkg::KIND_FLUSH, 20'hfffff);
    send_req(fbw_tb_pkg::KIND_WRITE, 20'h00000);
    send_req(fbw_tb_pkg::KIND_WRITE, 20'h001ff);
    send_req(fbw_tb_pkg::KIND_WRITE, 20'h00e00);
    send_req(fbw_tb_pkg::KIND_WRITE, 20'hfffff);
    send_req(fbw_tb_pkg::KIND_FLUSH, 20'h00000);
    send_req(fbw_tb_pkg::KIND_FLUSH, 20'h5a5a5);
    for (int s = 0; s < fbw_pkg::SLOTS_PER_BLOCK; s++) begin
      send_req(fbw_tb_pkg::KIND_WRITE, sector_addr(8'h5a, fbw_pkg::SLOT_W'(s)));
    end
    send_req(fbw_tb_pkg::KIND_WRITE, sector_addr(8'hab, 3'd3));
    send_req(fbw_tb_pkg::KIND_WRITE, 20'h00200);
    send_req(fbw_tb_pkg::KIND_WRITE, 20'h003ff);
    for (int s = 0; s < fbw_pkg::SLOTS_PER_BLOCK; s++) begin
      if (s != 1) begin
        send_req(fbw_tb_pkg::KIND_WRITE, sector_addr(8'h00, fbw_pkg::SLOT_W'(s)));
      end
    end
    drain_idle();

    // no idling, with a long command stall while requests keep coming
    write_buffer_block(8'h00);
    run_random(PHASE_ITEMS, 20, -1);
    drain_idle();

    // sender idle
    write_buffer_block(fbw_pkg::BLOCK_W'($urandom));
    send_idle_pct = 46;
    run_random(PHASE_ITEMS, -1, -1);
    drain_idle();

    // receiver stalling, with a full pause mid-phase
    write_buffer_block(8'hff);
    send_idle_pct  = 0;
    recv_stall_pct = 46;
    run_random(PHASE_ITEMS, -1, 30);
    drain_idle();

    // both sides idle
    write_buffer_block(fbw_pkg::BLOCK_W'($urandom));
    send_idle_pct  = 31;
    recv_stall_pct = 31;
    run_random(PHASE_ITEMS, -1, -1);
    drain_idle();

    $display("run covered %0d requests and %0d flash commands", n_sent, checked);
    $display("buffer block at reset value, 0, 255 and random; four idle/stall mixes");
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
